### rtl/rtws_pkg.sv
`default_nettype none
package rtws_pkg;

    localparam int DEPTH       = 1024;
    localparam int VOLUME_BITS = 24;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TIME_W  = 17;
    localparam int VIN_W   = 24;
    localparam int SIDE_W  = 2;
    localparam int WIN_W   = 11;
    localparam int WSEC_W  = WIN_W + 6;
    localparam int ENTRY_W = TIME_W + VOLUME_BITS + SIDE_W;

    localparam int SUM_W   = VOLUME_BITS + CNT_W;
    localparam int SSUM_W  = SUM_W + 1;
    localparam int A_W     = CNT_W + 2;
    localparam int ACC_W   = 2 * A_W + CNT_W;
    localparam int MA_W    = (ACC_W > SUM_W) ? ACC_W : SUM_W;
    localparam int PROD_W  = MA_W + CNT_W;
    localparam int DIV_W   = PROD_W + 16;
    localparam int DCNT_W  = $clog2(DIV_W);

    localparam int IN_W    = 48;
    localparam int OUT_W   = 216;

    localparam int O_TC_W   = 11;
    localparam int O_TV_W   = 35;
    localparam int O_BC_W   = 11;
    localparam int O_IR_W   = 36;
    localparam int O_IN_W   = 28;
    localparam int O_MV_W   = 32;
    localparam int O_BF_W   = 17;
    localparam int O_COV_W  = 20;
    localparam int O_CORR_W = 24;

    localparam int WIN_RESET = 5;
    localparam int CORR_MAX  = 4194304;

    localparam logic [SIDE_W-1:0] SIDE_NONE = 2'b00;
    localparam logic [SIDE_W-1:0] SIDE_BUY  = 2'b01;
    localparam logic [SIDE_W-1:0] SIDE_SELL = 2'b11;

    typedef enum logic [2:0] {
        DV_IMB,
        DV_MEAN,
        DV_BFRAC,
        DV_COV,
        DV_CORR
    } t_div_sel;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                  input logic [CNT_W-1:0] k);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(p) + (CNT_W+1)'(k);
        if (s >= (CNT_W+1)'(DEPTH)) begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/rtws_ram.sv
`default_nettype none
module rtws_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic                 i_re,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/rtws_div.sv
`default_nettype none
module rtws_div import rtws_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_sh, n_sh;
    logic [DIV_W-1:0]  r_den, n_den;
    logic [DIV_W:0]    w_try;
    logic [DIV_W:0]    w_sub;
    logic              w_ge;

    assign w_try = {r_rem, r_sh[DIV_W-1]};
    assign w_sub = w_try - {1'b0, r_den};
    assign w_ge  = w_try >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_sh   = r_sh;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_sh   = i_req.num;
            n_den  = i_req.den;
        end else if (r_busy) begin
            n_rem = w_ge ? w_sub[DIV_W-1:0] : w_try[DIV_W-1:0];
            n_sh  = {r_sh[DIV_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DCNT_W'(DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_sh  <= n_sh;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_sh;

endmodule
`default_nettype wire

### rtl/rolling_trade_window_stats.sv
`default_nettype none
// Rolling statistics over a time window of trade ticks, one result per tick.
// Expiry reads and checks the oldest entries one at a time, and the initiator
// autocovariance pass then walks the store one entry a cycle, both through
// its single read port; five quotients then go through one shared 64-step
// divider. The store needs no clearing after reset. Results wait in an output
// register while the next tick is taken.
module rolling_trade_window_stats import rtws_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // tick_time, volume, initiator
    input  wire logic [IN_W-1:0]    s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // trade_count, total_volume, buyer_count, imbalance_raw,
    // imbalance_normalized, mean_volume, buyer_fraction, initiator_autocov,
    // initiator_autocorr, window_overflow
    output logic      [OUT_W-1:0]   m_axis_tdata,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [WIN_W-1:0]   i_cfg_data
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_OVF     = 11'b00000000010,
        S_WR      = 11'b00000000100,
        S_EXP_RD  = 11'b00000001000,
        S_EXP_CHK = 11'b00000010000,
        S_PASS    = 11'b00000100000,
        S_SQ      = 11'b00001000000,
        S_MNUM    = 11'b00010000000,
        S_MDEN    = 11'b00100000000,
        S_DIV     = 11'b01000000000,
        S_OUT     = 11'b10000000000
    } t_state;

    t_state                    r_state, n_state;
    logic [PTR_W-1:0]          r_ptr, n_ptr;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [SUM_W-1:0]          r_vsum, n_vsum;
    logic [CNT_W-1:0]          r_bsum, n_bsum;
    logic signed [SSUM_W-1:0]  r_ssum, n_ssum;
    logic [WSEC_W-1:0]         r_win_sec, n_win_sec;
    logic                      r_ovalid, n_ovalid;
    logic                      r_div_start, n_div_start;

    logic [TIME_W-1:0]         r_t, n_t;
    logic [VOLUME_BITS-1:0]    r_vol, n_vol;
    logic [SIDE_W-1:0]         r_x, n_x;
    logic                      r_ovf, n_ovf;
    logic [CNT_W-1:0]          r_iss, n_iss;
    logic                      r_dv, n_dv;
    logic                      r_have_prev, n_have_prev;
    logic signed [A_W-1:0]     r_aprev, n_aprev;
    logic signed [ACC_W-1:0]   r_p, n_p;
    logic [ACC_W-1:0]          r_q, n_q;
    logic [MA_W-1:0]           r_nn, n_nn;
    logic [DIV_W-1:0]          r_num, n_num;
    logic [DIV_W-1:0]          r_den, n_den;
    t_div_sel                  r_sel, n_sel;
    logic [DIV_W-1:0]          r_q_imb, n_q_imb;
    logic [DIV_W-1:0]          r_q_mean, n_q_mean;
    logic [DIV_W-1:0]          r_q_bf, n_q_bf;
    logic [DIV_W-1:0]          r_q_cov, n_q_cov;
    logic [DIV_W-1:0]          r_q_corr, n_q_corr;
    logic [OUT_W-1:0]          r_odata, n_odata;

    logic                      ram_we, ram_re;
    logic [PTR_W-1:0]          ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]        ram_wdata, ram_rdata;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;

    logic [TIME_W-1:0]         rd_time;
    logic [VOLUME_BITS-1:0]    rd_vol;
    logic [SIDE_W-1:0]         rd_side;
    logic [SUM_W-1:0]          d_vsum;
    logic [CNT_W-1:0]          d_bsum;
    logic signed [SSUM_W-1:0]  d_ssum;
    logic signed [SSUM_W-1:0]  w_rd_vol_s, w_new_vol_s;
    logic [TIME_W:0]           w_exp_sum;
    logic                      w_expired;
    logic [SIDE_W-1:0]         w_in_side;
    logic signed [A_W-1:0]     w_n_s, w_b2, w_a;
    logic signed [2*A_W-1:0]   w_aa, w_ap;
    logic [SSUM_W-1:0]         w_smag;
    logic [ACC_W-1:0]          w_pmag;
    logic [CNT_W-1:0]          w_nm1;
    logic [MA_W-1:0]           w_ma;
    logic [CNT_W-1:0]          w_mb;
    logic [PROD_W-1:0]         w_prod;
    logic [DIV_W-1:0]          w_imb_s, w_cov_s, w_corr_s;
    logic [DIV_W-1:0]          w_corr_m;
    logic [O_MV_W-1:0]         w_mean;
    logic                      w_vz, w_pz;

    rtws_ram #(
        .W (ENTRY_W),
        .D (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rtws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign rd_time = ram_rdata[TIME_W-1:0];
    assign rd_vol  = ram_rdata[TIME_W +: VOLUME_BITS];
    assign rd_side = ram_rdata[TIME_W+VOLUME_BITS +: SIDE_W];

    assign w_rd_vol_s  = signed'(SSUM_W'(rd_vol));
    assign w_new_vol_s = signed'(SSUM_W'(r_vol));

    always_comb begin
        d_vsum = r_vsum - SUM_W'(rd_vol);
        d_bsum = (rd_side == SIDE_BUY) ? r_bsum - 1'b1 : r_bsum;
        case (rd_side)
            SIDE_BUY:  d_ssum = r_ssum - w_rd_vol_s;
            SIDE_SELL: d_ssum = r_ssum + w_rd_vol_s;
            default:   d_ssum = r_ssum;
        endcase
    end

    assign w_exp_sum = (TIME_W+1)'(rd_time) + (TIME_W+1)'(r_win_sec);
    assign w_expired = w_exp_sum <= (TIME_W+1)'(r_t);

    always_comb begin
        case (s_axis_tdata[41 +: SIDE_W])
            SIDE_NONE: w_in_side = SIDE_NONE;
            SIDE_BUY:  w_in_side = SIDE_BUY;
            default:   w_in_side = SIDE_SELL;
        endcase
    end

    assign w_n_s = signed'(A_W'(r_cnt));
    assign w_b2  = signed'(A_W'({r_bsum, 1'b0}));

    always_comb begin
        case (rd_side)
            SIDE_BUY:  w_a = (w_n_s <<< 1) - w_b2;
            SIDE_SELL: w_a = -w_b2;
            default:   w_a = w_n_s - w_b2;
        endcase
    end

    assign w_aa = w_a * w_a;
    assign w_ap = r_aprev * w_a;

    assign w_smag = r_ssum[SSUM_W-1] ? SSUM_W'(-r_ssum) : SSUM_W'(r_ssum);
    assign w_pmag = r_p[ACC_W-1] ? ACC_W'(-r_p) : ACC_W'(r_p);
    assign w_nm1  = r_cnt - 1'b1;
    assign w_prod = PROD_W'(w_ma) * PROD_W'(w_mb);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_SQ: begin
                w_ma = MA_W'(r_cnt);
                w_mb = r_cnt;
            end
            S_MNUM: begin
                case (r_sel)
                    DV_IMB:   begin w_ma = MA_W'(w_smag); w_mb = r_cnt; end
                    DV_MEAN:  begin w_ma = MA_W'(r_vsum); w_mb = CNT_W'(1); end
                    DV_BFRAC: begin w_ma = MA_W'(r_bsum); w_mb = CNT_W'(1); end
                    DV_COV:   begin w_ma = MA_W'(w_pmag); w_mb = CNT_W'(1); end
                    DV_CORR:  begin w_ma = MA_W'(w_pmag); w_mb = r_cnt; end
                    default:  begin w_ma = '0; w_mb = '0; end
                endcase
            end
            S_MDEN: begin
                case (r_sel)
                    DV_IMB:   begin w_ma = MA_W'(r_vsum); w_mb = CNT_W'(1); end
                    DV_MEAN:  begin w_ma = MA_W'(r_cnt); w_mb = CNT_W'(1); end
                    DV_BFRAC: begin w_ma = MA_W'(r_cnt); w_mb = CNT_W'(1); end
                    DV_COV:   begin w_ma = r_nn; w_mb = w_nm1; end
                    DV_CORR:  begin w_ma = MA_W'(r_q); w_mb = w_nm1; end
                    default:  begin w_ma = '0; w_mb = '0; end
                endcase
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_vz     = (r_vsum == '0);
    assign w_pz     = (r_cnt < CNT_W'(2)) || (r_p == '0);
    assign w_imb_s  = r_ssum[SSUM_W-1] ? (~r_q_imb + 1'b1) : r_q_imb;
    assign w_cov_s  = r_p[ACC_W-1] ? (~r_q_cov + 1'b1) : r_q_cov;
    assign w_corr_m = (r_q_corr > DIV_W'(CORR_MAX)) ? DIV_W'(CORR_MAX) : r_q_corr;
    assign w_corr_s = r_p[ACC_W-1] ? (~w_corr_m + 1'b1) : w_corr_m;
    assign w_mean   = (r_q_mean[DIV_W-1:O_MV_W] != '0) ? '1 : r_q_mean[O_MV_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_vsum      = r_vsum;
        n_bsum      = r_bsum;
        n_ssum      = r_ssum;
        n_win_sec   = r_win_sec;
        n_ovalid    = r_ovalid;
        n_div_start = 1'b0;
        n_t         = r_t;
        n_vol       = r_vol;
        n_x         = r_x;
        n_ovf       = r_ovf;
        n_iss       = r_iss;
        n_dv        = r_dv;
        n_have_prev = r_have_prev;
        n_aprev     = r_aprev;
        n_p         = r_p;
        n_q         = r_q;
        n_nn        = r_nn;
        n_num       = r_num;
        n_den       = r_den;
        n_sel       = r_sel;
        n_q_imb     = r_q_imb;
        n_q_mean    = r_q_mean;
        n_q_bf      = r_q_bf;
        n_q_cov     = r_q_cov;
        n_q_corr    = r_q_corr;
        n_odata     = r_odata;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = wrap_add(r_ptr, r_cnt);
        ram_raddr   = r_ptr;
        ram_wdata   = {r_x, r_vol, r_t};

        if (i_cfg_valid) begin
            n_win_sec = WSEC_W'({i_cfg_data, 6'b0}) - WSEC_W'({i_cfg_data, 2'b0});
        end

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_t   = s_axis_tdata[TIME_W-1:0];
                    n_vol = s_axis_tdata[17 +: VOLUME_BITS];
                    n_x   = w_in_side;
                    n_ovf = 1'b0;
                    if (r_cnt == CNT_W'(DEPTH)) begin
                        ram_re  = 1'b1;
                        n_state = S_OVF;
                    end else begin
                        n_state = S_WR;
                    end
                end
            end
            S_OVF: begin
                n_vsum  = d_vsum;
                n_bsum  = d_bsum;
                n_ssum  = d_ssum;
                n_ptr   = wrap_add(r_ptr, CNT_W'(1));
                n_cnt   = r_cnt - 1'b1;
                n_ovf   = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                ram_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                n_vsum = r_vsum + SUM_W'(r_vol);
                if (r_x == SIDE_BUY) begin
                    n_bsum = r_bsum + 1'b1;
                    n_ssum = r_ssum + w_new_vol_s;
                end else if (r_x == SIDE_SELL) begin
                    n_ssum = r_ssum - w_new_vol_s;
                end
                n_state = S_EXP_RD;
            end
            S_EXP_RD: begin
                ram_re  = 1'b1;
                n_state = S_EXP_CHK;
            end
            S_EXP_CHK: begin
                if (r_cnt > CNT_W'(1) && w_expired) begin
                    n_vsum  = d_vsum;
                    n_bsum  = d_bsum;
                    n_ssum  = d_ssum;
                    n_ptr   = wrap_add(r_ptr, CNT_W'(1));
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_EXP_RD;
                end else begin
                    n_iss       = '0;
                    n_dv        = 1'b0;
                    n_have_prev = 1'b0;
                    n_p         = '0;
                    n_q         = '0;
                    n_state     = S_PASS;
                end
            end
            S_PASS: begin
                if (r_iss != r_cnt) begin
                    ram_re    = 1'b1;
                    ram_raddr = wrap_add(r_ptr, r_iss);
                    n_iss     = r_iss + 1'b1;
                    n_dv      = 1'b1;
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    n_q = r_q + ACC_W'($unsigned(w_aa));
                    if (r_have_prev) begin
                        n_p = r_p + ACC_W'(w_ap);
                    end
                    n_aprev     = w_a;
                    n_have_prev = 1'b1;
                end else if (r_iss == r_cnt) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_nn    = w_prod[MA_W-1:0];
                n_sel   = DV_IMB;
                n_state = S_MNUM;
            end
            S_MNUM: begin
                if (r_sel == DV_MEAN) begin
                    n_num = DIV_W'(w_prod) << 8;
                end else begin
                    n_num = DIV_W'(w_prod) << 16;
                end
                n_state = S_MDEN;
            end
            S_MDEN: begin
                n_den       = DIV_W'(w_prod);
                n_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_MNUM;
                    case (r_sel)
                        DV_IMB: begin
                            n_q_imb = div_rsp.quot;
                            n_sel   = DV_MEAN;
                        end
                        DV_MEAN: begin
                            n_q_mean = div_rsp.quot;
                            n_sel    = DV_BFRAC;
                        end
                        DV_BFRAC: begin
                            n_q_bf = div_rsp.quot;
                            n_sel  = DV_COV;
                        end
                        DV_COV: begin
                            n_q_cov = div_rsp.quot;
                            n_sel   = DV_CORR;
                        end
                        default: begin
                            n_q_corr = div_rsp.quot;
                            n_state  = S_OUT;
                        end
                    endcase
                end
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_odata = {
                        1'b0,
                        r_ovf,
                        (w_pz || r_q == '0) ? O_CORR_W'(0) : w_corr_s[O_CORR_W-1:0],
                        w_pz ? O_COV_W'(0) : w_cov_s[O_COV_W-1:0],
                        r_q_bf[O_BF_W-1:0],
                        w_mean,
                        w_vz ? O_IN_W'(0) : w_imb_s[O_IN_W-1:0],
                        w_vz ? O_IR_W'(0) : O_IR_W'(r_ssum),
                        O_BC_W'(r_bsum),
                        O_TV_W'(r_vsum),
                        O_TC_W'(r_cnt)
                    };
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_vsum      <= '0;
            r_bsum      <= '0;
            r_ssum      <= '0;
            r_win_sec   <= WSEC_W'(WIN_RESET * 60);
            r_ovalid    <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_cnt       <= n_cnt;
            r_vsum      <= n_vsum;
            r_bsum      <= n_bsum;
            r_ssum      <= n_ssum;
            r_win_sec   <= n_win_sec;
            r_ovalid    <= n_ovalid;
            r_div_start <= n_div_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t         <= n_t;
        r_vol       <= n_vol;
        r_x         <= n_x;
        r_ovf       <= n_ovf;
        r_iss       <= n_iss;
        r_dv        <= n_dv;
        r_have_prev <= n_have_prev;
        r_aprev     <= n_aprev;
        r_p         <= n_p;
        r_q         <= n_q;
        r_nn        <= n_nn;
        r_num       <= n_num;
        r_den       <= n_den;
        r_sel       <= n_sel;
        r_q_imb     <= n_q_imb;
        r_q_mean    <= n_q_mean;
        r_q_bf      <= n_q_bf;
        r_q_cov     <= n_q_cov;
        r_q_corr    <= n_q_corr;
        r_odata     <= n_odata;
    end

    assign div_req.start = r_div_start;
    assign div_req.num   = r_num;
    assign div_req.den   = r_den;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign o_cfg_ready   = 1'b1;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("window count above store depth");

    a_buy_le_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bsum <= r_cnt)
        else $error("buyer count above window count");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("new item taken while one is in work");

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && n_state == S_IDLE |=> m_axis_tvalid)
        else $error("finished item not posted");
`endif

endmodule
`default_nettype wire

### tb/sv/rtws_checker.sv
`timescale 1ns / 1ps
module rtws_checker import rtws_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    input  wire logic             s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    input  wire logic             m_axis_tvalid,
    input  wire logic             m_axis_tready,
    input  wire logic [OUT_W-1:0] m_axis_tdata,
    input  wire logic             i_cfg_valid,
    input  wire logic             o_cfg_ready,
    input  wire logic [WIN_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int EXP_SLOTS = 16;

    typedef struct packed {
        logic                pad;
        logic                overflow;
        logic [O_CORR_W-1:0] autocorr;
        logic [O_COV_W-1:0]  autocov;
        logic [O_BF_W-1:0]   buy_frac;
        logic [O_MV_W-1:0]   mean_vol;
        logic [O_IN_W-1:0]   imb_norm;
        logic [O_IR_W-1:0]   imb_raw;
        logic [O_BC_W-1:0]   buy_cnt;
        logic [O_TV_W-1:0]   tot_vol;
        logic [O_TC_W-1:0]   trd_cnt;
    } t_stats;

    logic [TIME_W-1:0] time_mem [DEPTH];
    longint            vol_mem  [DEPTH];
    int                side_mem [DEPTH];
    int                head = 0;
    int                fill = 0;
    longint            vol_total = 0;
    int                buy_total = 0;
    longint            signed_total = 0;
    int                window_min = WIN_RESET;
    t_stats            exp_mem [EXP_SLOTS];
    int                exp_put = 0;
    int                exp_take = 0;
    int                mismatches = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = exp_put - exp_take;

    function automatic logic [63:0] scaled_quot(logic [63:0] a, logic [63:0] b,
                                                logic [63:0] d);
        logic [127:0] p;
        if (d == 0) begin
            return '1;
        end
        p = 128'(a) * 128'(b);
        p = p / 128'(d);
        return p[63:0];
    endfunction

    function automatic longint magn(longint v);
        return v < 0 ? -v : v;
    endfunction

    task automatic evict_front();
        vol_total    -= vol_mem[head];
        if (side_mem[head] > 0) begin
            buy_total--;
        end
        signed_total -= side_mem[head] * vol_mem[head];
        head = (head + 1) % DEPTH;
        fill--;
    endtask

    task automatic predict_stats(logic [IN_W-1:0] d);
        logic [TIME_W-1:0] t;
        longint            v;
        int                x;
        int                pos;
        int                n;
        longint            cutoff;
        longint            s_sum;
        longint            c;
        longint            a;
        longint            b;
        longint            p;
        longint            q;
        longint            imb;
        longint            cov;
        longint            corr;
        logic [63:0]       mean;
        logic [63:0]       m;
        t_stats            r;
        t     = d[16:0];
        v     = longint'(d[40:17]);
        x     = (d[42:41] == SIDE_BUY) ? 1 : (d[42:41] == SIDE_NONE) ? 0 : -1;
        r     = '0;
        if (fill >= DEPTH) begin
            evict_front();
            r.overflow = 1'b1;
        end
        pos           = (head + fill) % DEPTH;
        time_mem[pos] = t;
        vol_mem[pos]  = v;
        side_mem[pos] = x;
        fill++;
        vol_total += v;
        if (x > 0) begin
            buy_total++;
        end
        signed_total += x * v;
        cutoff = longint'(t) - longint'(window_min) * 60;
        while (fill > 1 && longint'(time_mem[head]) <= cutoff) begin
            evict_front();
        end
        n     = fill;
        s_sum = signed_total;
        imb   = 0;
        if (vol_total == 0) begin
            s_sum = 0;
        end else begin
            imb = longint'(scaled_quot(magn(s_sum), longint'(n) << 16, vol_total));
            if (s_sum < 0) begin
                imb = -imb;
            end
        end
        mean = scaled_quot(vol_total, 256, n);
        if (mean > 64'hFFFF_FFFF) begin
            mean = 64'hFFFF_FFFF;
        end
        c = 2 * buy_total - n;
        p = 0;
        q = 0;
        for (int k = 0; k < n; k++) begin
            a = n * side_mem[(head + k) % DEPTH] - c;
            q += a * a;
            if (k + 1 < n) begin
                b = n * side_mem[(head + k + 1) % DEPTH] - c;
                p += a * b;
            end
        end
        cov  = 0;
        corr = 0;
        if (n >= 2 && p != 0) begin
            m   = scaled_quot(magn(p), 65536, longint'(n) * n) / (n - 1);
            cov = (p < 0) ? -longint'(m) : longint'(m);
            m   = 0;
            if (q != 0) begin
                m = scaled_quot(magn(p), longint'(n) << 16, q) / (n - 1);
                if (m > CORR_MAX) begin
                    m = CORR_MAX;
                end
            end
            corr = (p < 0) ? -longint'(m) : longint'(m);
        end
        r.trd_cnt  = O_TC_W'(n);
        r.tot_vol  = O_TV_W'(vol_total);
        r.buy_cnt  = O_BC_W'(buy_total);
        r.imb_raw  = O_IR_W'(s_sum);
        r.imb_norm = O_IN_W'(imb);
        r.mean_vol = mean[31:0];
        r.buy_frac = O_BF_W'((longint'(buy_total) << 16) / n);
        r.autocov  = O_COV_W'(cov);
        r.autocorr = O_CORR_W'(corr);
        exp_mem[exp_put % EXP_SLOTS] = r;
        exp_put++;
    endtask

    function automatic logic [63:0] stat_field(t_stats r, int i);
        case (i)
            0: return 64'(r.trd_cnt);
            1: return 64'(r.tot_vol);
            2: return 64'(r.buy_cnt);
            3: return 64'(r.imb_raw);
            4: return 64'(r.imb_norm);
            5: return 64'(r.mean_vol);
            6: return 64'(r.buy_frac);
            7: return 64'(r.autocov);
            8: return 64'(r.autocorr);
            default: return 64'(r.overflow);
        endcase
    endfunction

    task automatic compare_stats(t_stats got);
        string  names [10] = '{"trade_count", "total_volume", "buyer_count",
                               "imbalance_raw", "imbalance_normalized", "mean_volume",
                               "buyer_fraction", "initiator_autocov",
                               "initiator_autocorr", "window_overflow"};
        t_stats want;
        if (exp_put == exp_take) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: unexpected result item %h", $realtime, got);
            end
            return;
        end
        want = exp_mem[exp_take % EXP_SLOTS];
        exp_take++;
        for (int i = 0; i < 10; i++) begin
            if (stat_field(got, i) !== stat_field(want, i)) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: %s expected %h got %h", $realtime, names[i],
                             stat_field(want, i), stat_field(got, i));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                window_min = int'(i_cfg_data);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_stats(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                compare_stats(t_stats'(m_axis_tdata));
            end
        end
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import rtws_pkg::*;

    localparam longint CYCLE_LIMIT = 24_000_000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [WIN_W-1:0] i_cfg_data = '0;
    int               fail_count;
    int               pending;
    bit               no_gaps = 1'b0;
    longint           cycles = 0;
    int               tick_clock = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    rolling_trade_window_stats uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    rtws_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stall before each item
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_tick(int t, logic [23:0] vol, logic [1:0] side);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, side, vol, TIME_W'(t)};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        do @(negedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_window(int minutes);
        s_axis_tvalid <= 1'b0;
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= WIN_W'(minutes);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_tick(int minutes);
        int          r;
        int          span;
        logic [23:0] vol;
        r    = $urandom_range(0, 19);
        span = minutes * 60 / 6 + 1;
        if (r == 0) begin
            tick_clock = $urandom_range(0, 86399);
        end else if (r == 1) begin
            tick_clock -= $urandom_range(0, tick_clock < 600 ? tick_clock : 600);
        end else begin
            tick_clock += $urandom_range(0, span);
        end
        if (tick_clock > 86399) begin
            tick_clock = $urandom_range(0, 3000);
        end
        case ($urandom_range(0, 5))
            0:       vol = '0;
            1:       vol = '1;
            2:       vol = 24'($urandom_range(0, 255));
            default: vol = 24'($urandom);
        endcase
        send_tick(tick_clock, vol, 2'($urandom_range(0, 3)));
    endtask

    initial begin
        int windows [7] = '{1, 30, 2047, 5, 1440, 0, 120};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset window, then 0, 2047 and 1 minutes: cutoff before midnight, all sides, volume extremes
        send_tick(0, '0, SIDE_NONE);
        send_tick(0, '1, SIDE_BUY);
        send_tick(1, '1, SIDE_SELL);
        send_tick(2, 24'd5, 2'b10);
        send_tick(400, 24'd10, SIDE_BUY);
        send_tick(100, 24'd20, SIDE_SELL);
        send_tick(50, 24'd30, SIDE_BUY);
        send_tick(700, 24'd40, SIDE_NONE);
        send_tick(86399, '0, SIDE_NONE);
        send_tick(86399, '1, SIDE_SELL);
        send_tick(65536, 24'h800000, SIDE_BUY);
        set_window(0);
        send_tick(1000, 24'd7, SIDE_BUY);
        send_tick(1000, 24'd9, SIDE_SELL);
        send_tick(999, 24'd3, SIDE_BUY);
        set_window(2047);
        send_tick(86399, '1, SIDE_BUY);
        send_tick(0, '1, SIDE_BUY);
        send_tick(131071, 24'd1, SIDE_SELL);
        set_window(1);
        send_tick(60, 24'd2, SIDE_BUY);
        send_tick(120, 24'd2, SIDE_BUY);
        send_tick(181, 24'd2, SIDE_SELL);

        for (int ph = 0; ph < 7; ph++) begin
            set_window(windows[ph]);
            tick_clock = $urandom_range(0, 40000);
            for (int i = 0; i < 74; i++) begin
                if (i % 25 == 0) begin
                    no_gaps = ($urandom_range(0, 3) == 0);
                end
                random_tick(windows[ph]);
            end
        end

        s_axis_tvalid <= 1'b0;
        drain();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
